### rtl/core/ghash_pkg.sv
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared types, constants and GF(2^128) helpers for the GHASH engine.
// ----------------------------------------------------------------------------
package ghash_pkg;

    localparam int unsigned DIGIT_BITS_DEF = 4;
    localparam int unsigned BLOCK_BITS     = 128;
    localparam int unsigned WORD_BITS      = 64;
    localparam int unsigned BLOCK_BYTES    = 16;
    localparam int unsigned MAX_DIGIT_BITS = 8;

    // reduction constant in gcm bit order (x^0 at the msb)
    localparam logic [BLOCK_BITS-1:0] REDUCE_POLY = {8'he1, 120'd0};

    localparam logic ACTION_CLEAR  = 1'b0;
    localparam logic ACTION_ABSORB = 1'b1;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef logic [BLOCK_BITS-1:0] block_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DONE
    } mac_state_t;

    typedef enum logic [1:0] {
        KG_POWERS,
        KG_FILL,
        KG_IDLE
    } keygen_state_t;

    // multiply by x^n, n up to eight; the bits that drop off the low end
    // each fold one copy of the reduction constant into the high word
    function automatic block_t shift_x(block_t v, int unsigned n);
        block_t      r;
        int unsigned k;
        r = v >> n;
        for (k = 0; k < MAX_DIGIT_BITS; k++)
        begin
            if ((k < n) && v[k])
            begin
                r = r ^ (REDUCE_POLY >> (n - 1 - k));
            end
        end
        return r;
    endfunction

    // keep the first n bytes, byte 0 at the msb end
    function automatic block_t mask_block(block_t v, logic [4:0] n);
        block_t      r;
        int unsigned b;
        r = v;
        for (b = 0; b < BLOCK_BYTES; b++)
        begin
            if (5'(b) >= n)
            begin
                r[BLOCK_BITS-1-8*b -: 8] = 8'd0;
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/ghash_table.sv
// ----------------------------------------------------------------------------
// ghash_table
// Key multiple table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ghash_table #(
    parameter int unsigned DIGIT_BITS = ghash_pkg::DIGIT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [DIGIT_BITS-1:0] wr_addr,
    input  ghash_pkg::block_t     wr_data,
    input  logic [DIGIT_BITS-1:0] rd_addr,
    output ghash_pkg::block_t     rd_data
);

    localparam int unsigned DEPTH = 1 << DIGIT_BITS;

    ghash_pkg::block_t mem [DEPTH];
    ghash_pkg::block_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/ghash_keygen.sv
// ----------------------------------------------------------------------------
// ghash_keygen
// Rebuilds the key multiple table: first H * x^j for each digit bit, then
// one table entry per cycle as the xor of the powers its digit selects.
// ----------------------------------------------------------------------------
module ghash_keygen #(
    parameter int unsigned DIGIT_BITS = ghash_pkg::DIGIT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ghash_pkg::block_t     key,
    output logic                  busy,
    output logic                  wr_en,
    output logic [DIGIT_BITS-1:0] wr_addr,
    output ghash_pkg::block_t     wr_data
);

    localparam int unsigned POW_W = (DIGIT_BITS > 1) ? $clog2(DIGIT_BITS) : 1;

    ghash_pkg::keygen_state_t state_reg, state_next;
    logic [POW_W-1:0]         pow_cnt_reg, pow_cnt_next;
    logic [DIGIT_BITS-1:0]    fill_cnt_reg, fill_cnt_next;
    ghash_pkg::block_t        pow_reg [DIGIT_BITS];
    ghash_pkg::block_t        entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset runs a full build from the zero key, which clears the table
            state_reg    <= ghash_pkg::KG_POWERS;
            pow_cnt_reg  <= '0;
            fill_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pow_cnt_reg  <= pow_cnt_next;
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ghash_pkg::KG_POWERS) && !start)
        begin
            if (pow_cnt_reg == '0)
            begin
                pow_reg[0] <= key;
            end
            else
            begin
                pow_reg[pow_cnt_reg] <= ghash_pkg::shift_x(pow_reg[pow_cnt_reg - 1'b1], 1);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        pow_cnt_next  = pow_cnt_reg;
        fill_cnt_next = fill_cnt_reg;
        wr_en         = 1'b0;
        if (start)
        begin
            state_next   = ghash_pkg::KG_POWERS;
            pow_cnt_next = '0;
        end
        else
        begin
            unique case (state_reg)
                ghash_pkg::KG_POWERS:
                begin
                    if (pow_cnt_reg == POW_W'(DIGIT_BITS - 1))
                    begin
                        state_next    = ghash_pkg::KG_FILL;
                        fill_cnt_next = '0;
                    end
                    else
                    begin
                        pow_cnt_next = pow_cnt_reg + 1'b1;
                    end
                end
                ghash_pkg::KG_FILL:
                begin
                    wr_en = 1'b1;
                    if (fill_cnt_reg == '1)
                    begin
                        state_next = ghash_pkg::KG_IDLE;
                    end
                    else
                    begin
                        fill_cnt_next = fill_cnt_reg + 1'b1;
                    end
                end
                ghash_pkg::KG_IDLE:
                begin
                end
                default:
                begin
                    state_next = ghash_pkg::KG_IDLE;
                end
            endcase
        end
    end

    // digit msb stands for x^0, so bit DIGIT_BITS-1-j selects H * x^j
    always_comb
    begin
        entry = '0;
        for (int j = 0; j < DIGIT_BITS; j++)
        begin
            if (fill_cnt_reg[DIGIT_BITS-1-j])
            begin
                entry = entry ^ pow_reg[j];
            end
        end
    end

    assign busy    = (state_reg != ghash_pkg::KG_IDLE);
    assign wr_addr = fill_cnt_reg;
    assign wr_data = entry;

endmodule

### rtl/core/ghash_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// ghash_multiply_accumulate
// GHASH multiply-accumulate engine with a table driven digit multiplier.
// ----------------------------------------------------------------------------
// Input beats carry action, block_high, block_low and valid_bytes on a
// valid/stall channel. An absorb beat xors the leading valid_bytes of the
// block into the accumulator and multiplies the sum by H; a clear beat zeroes
// the accumulator. Each beat returns one output beat holding the new
// accumulator on digest_high/digest_low.
// An absorb takes 128/DIGIT_BITS table reads (plus one for a short leading
// digit), one per cycle from the single read port of the table memory. One
// item is worked on at a time; the next one is taken as soon as the result
// sits in the output register, even while the receiver still stalls it.
// Writing either key register rebuilds the table, with in_stall high
// meanwhile. Reset zeroes the keys and the accumulator and runs the same
// build from the zero key to clear the table, so in_stall stays high after
// reset until that build is done.
// A stalled output beat holds, and a finished item waits for it to drain.
// ----------------------------------------------------------------------------
module ghash_multiply_accumulate #(
    parameter int unsigned DIGIT_BITS = ghash_pkg::DIGIT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic [4:0]  valid_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_high,
    output logic [63:0] digest_low
);

    localparam int unsigned FULL       = ghash_pkg::BLOCK_BITS / DIGIT_BITS;
    localparam int unsigned PART       = ghash_pkg::BLOCK_BITS % DIGIT_BITS;
    localparam int unsigned STEPS      = FULL + ((PART != 0) ? 1 : 0);
    localparam int unsigned CNT_W      = $clog2(STEPS + 1);
    localparam int unsigned PART_SHIFT = (PART != 0) ? (DIGIT_BITS - PART) : 0;

    logic [63:0]           key_high_reg, key_low_reg;
    ghash_pkg::mac_state_t state_reg, state_next;
    ghash_pkg::block_t     acc_reg, acc_next;
    ghash_pkg::block_t     x_reg, x_next;
    ghash_pkg::block_t     z_reg, z_next;
    logic [CNT_W-1:0]      step_cnt_reg, step_cnt_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  rd_part_reg, rd_part_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  kg_busy;
    logic                  tbl_wr_en;
    logic [DIGIT_BITS-1:0] tbl_wr_addr;
    ghash_pkg::block_t     tbl_wr_data;
    logic [DIGIT_BITS-1:0] tbl_rd_addr;
    ghash_pkg::block_t     tbl_rd_data;

    logic                  in_accept;
    logic                  out_free;
    logic                  is_part_step;
    logic                  rd_issue;
    ghash_pkg::block_t     z_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ghash_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                ghash_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ghash_keygen #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_keygen (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_write),
        .key     ({key_high_reg, key_low_reg}),
        .busy    (kg_busy),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    ghash_table #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ghash_pkg::ST_IDLE;
            acc_reg       <= '0;
            step_cnt_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            rd_part_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            step_cnt_reg  <= step_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            rd_part_reg   <= rd_part_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        z_reg <= z_next;
    end

    assign in_stall  = (state_reg != ghash_pkg::ST_IDLE) || kg_busy;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // digits come off the low end of the sum; a short leading digit is last
    assign is_part_step = (PART != 0) && (step_cnt_reg == CNT_W'(FULL));
    assign tbl_rd_addr  = is_part_step ? (x_reg[DIGIT_BITS-1:0] << PART_SHIFT)
                                       : x_reg[DIGIT_BITS-1:0];

    assign z_step = (rd_part_reg ? ghash_pkg::shift_x(z_reg, PART)
                                 : ghash_pkg::shift_x(z_reg, DIGIT_BITS)) ^ tbl_rd_data;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        z_next         = rd_valid_reg ? z_step : z_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        rd_issue       = 1'b0;
        unique case (state_reg)
            ghash_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    z_next        = '0;
                    step_cnt_next = '0;
                    if (action == ghash_pkg::ACTION_CLEAR)
                    begin
                        state_next = ghash_pkg::ST_DONE;
                    end
                    else
                    begin
                        x_next     = acc_reg ^ ghash_pkg::mask_block({block_high, block_low},
                                                                     valid_bytes);
                        state_next = ghash_pkg::ST_MUL;
                    end
                end
            end
            ghash_pkg::ST_MUL:
            begin
                rd_issue      = 1'b1;
                x_next        = x_reg >> DIGIT_BITS;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == CNT_W'(STEPS - 1))
                begin
                    state_next = ghash_pkg::ST_DONE;
                end
            end
            ghash_pkg::ST_DONE:
            begin
                // last table read folds in first, then the result goes out
                if (!rd_valid_reg && out_free)
                begin
                    acc_next       = z_reg;
                    out_valid_next = 1'b1;
                    state_next     = ghash_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ghash_pkg::ST_IDLE;
            end
        endcase
        rd_valid_next = rd_issue;
        rd_part_next  = rd_issue && is_part_step;
    end

    assign out_valid   = out_valid_reg;
    assign digest_high = acc_reg[127:64];
    assign digest_low  = acc_reg[63:0];

endmodule

### rtl/core/ghash_checker.sv
// ----------------------------------------------------------------------------
// ghash_checker
// Port level checks on the GHASH engine, bound to the top level.
// ----------------------------------------------------------------------------
module ghash_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] digest_high,
    input logic [63:0] digest_low
);

    // one item in flight: an accepted beat blocks the next cycle
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on the cycle after an accepted beat");

    // a key write starts a table rebuild
    a_key_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> in_stall)
        else $error("input not stalled after a key write");

    // a result only appears while the engine is busy with an item
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_high) && $stable(digest_low))
        else $error("stalled output beat changed");

endmodule

bind ghash_multiply_accumulate ghash_checker u_ghash_checker (.*);
